FILE: src/urdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the CRC-8 byte update for the UART reply deframer.
// No dependencies; imported by urdc_out_buf and uart_reply_deframer_crc8.
package urdc_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd1;

  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_BYTE  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;
  localparam logic [1:0] FN_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0]  SYNC_RST    = 8'h05;
  localparam logic [15:0] TIMEOUT_RST = 16'd20;
  localparam logic [7:0]  SYNC_MID    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [2:0]  LAST_DATA   = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_SEARCH  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
  } res_t;

  // CRC-8, poly 0x07, byte taken LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ b[k];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  localparam logic [7:0] PRE_CRC_RST = crc8_byte(crc8_byte(8'h00, SYNC_RST), SYNC_MID);

endpackage

FILE: src/urdc_out_buf.sv
`timescale 1ns / 1ps
// Result output register with one skid entry for the reply deframer.
// Depends on urdc_pkg for res_t.
module urdc_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  urdc_pkg::res_t  push_res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output urdc_pkg::res_t  out_res
);
  import urdc_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = push;
        skid_res_nxt   = push_res;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: src/uart_reply_deframer_crc8.sv
`timescale 1ns / 1ps
// UART reply deframer: sync search, 4-byte data collection, CRC-8 check, timeout.
// A result is registered in urdc_out_buf (output register, or its skid entry while out_stall holds) before out_*.
// Throughput: one input word per cycle while in_stall is low; the CRC advances one byte per collected data word.
// in_stall rises only when both the output register and its skid entry are full.
// Reset (synchronous, rst_n low): idle, config back to sync 0x05 and timeout 20.
// Depends on urdc_pkg and urdc_out_buf.
module uart_reply_deframer_crc8 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_reg_addr,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_reg_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urdc_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import urdc_pkg::*;

  logic [7:0]  sync_r, sync_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [7:0]  pre_crc_r, pre_crc_nxt;

  phase_t      phase_r, phase_nxt;
  logic [23:0] window_r, window_nxt;
  logic [7:0]  exp_addr_r, exp_addr_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] data_r, data_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  crc_r, crc_nxt;

  logic        in_accept;
  logic        cfg_accept;
  logic        res_push;
  res_t        res;
  res_t        out_res;
  logic        buf_full;

  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_comb begin
    sync_nxt    = sync_r;
    timeout_nxt = timeout_r;
    pre_crc_nxt = pre_crc_r;
    if (cfg_accept) begin
      if (cfg_index == REG_SYNC) begin
        sync_nxt    = cfg_wdata[7:0];
        pre_crc_nxt = crc8_byte(crc8_byte(8'h00, cfg_wdata[7:0]), SYNC_MID);
      end else if (cfg_index == REG_TIMEOUT) begin
        timeout_nxt = cfg_wdata[15:0];
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    window_nxt   = window_r;
    exp_addr_nxt = exp_addr_r;
    cnt_nxt      = cnt_r;
    data_nxt     = data_r;
    ticks_nxt    = ticks_r;
    crc_nxt      = crc_r;
    res_push     = 1'b0;
    res.status   = ST_OK;
    res.data     = 32'h0;
    if (in_accept) begin
      unique case (in_func)
        FN_START: begin
          exp_addr_nxt = in_reg_addr;
          window_nxt   = 24'h0;
          cnt_nxt      = 3'd0;
          data_nxt     = 32'h0;
          ticks_nxt    = timeout_r;
          phase_nxt    = PH_SEARCH;
          if (timeout_r == 16'h0) begin
            phase_nxt  = PH_IDLE;
            res_push   = 1'b1;
            res.status = ST_TIMEOUT;
          end
        end
        FN_TICK: begin
          if (phase_r != PH_IDLE) begin
            ticks_nxt = ticks_r - 16'd1;
            if (ticks_nxt == 16'h0) begin
              phase_nxt  = PH_IDLE;
              res_push   = 1'b1;
              res.status = ST_TIMEOUT;
            end
          end
        end
        FN_BYTE: begin
          unique case (phase_r)
            PH_IDLE: begin
            end
            PH_SEARCH: begin
              window_nxt = {window_r[15:0], in_rx_byte};
              if (window_nxt == {sync_r, SYNC_MID, exp_addr_r}) begin
                phase_nxt = PH_COLLECT;
                cnt_nxt   = 3'd0;
                data_nxt  = 32'h0;
                ticks_nxt = timeout_r;
                crc_nxt   = crc8_byte(pre_crc_r, exp_addr_r);
                if (timeout_r == 16'h0) begin
                  phase_nxt  = PH_IDLE;
                  res_push   = 1'b1;
                  res.status = ST_TIMEOUT;
                end
              end
            end
            PH_COLLECT: begin
              data_nxt = {data_r[23:0], in_rx_byte};
              if (cnt_r == LAST_DATA) begin
                cnt_nxt   = 3'd0;
                phase_nxt = PH_IDLE;
                res_push  = 1'b1;
                if (crc_r != in_rx_byte || crc_r == 8'h00) begin
                  res.status = ST_CRC;
                end else begin
                  res.data = data_r;
                end
              end else begin
                cnt_nxt = cnt_r + 3'd1;
                crc_nxt = crc8_byte(crc_r, in_rx_byte);
              end
            end
            default: begin
            end
          endcase
        end
        FN_RSVD: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SYNC_RST;
      timeout_r <= TIMEOUT_RST;
      pre_crc_r <= PRE_CRC_RST;
      phase_r   <= PH_IDLE;
      cnt_r     <= 3'd0;
      ticks_r   <= 16'h0;
    end else begin
      sync_r    <= sync_nxt;
      timeout_r <= timeout_nxt;
      pre_crc_r <= pre_crc_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      ticks_r   <= ticks_nxt;
    end
    window_r   <= window_nxt;
    exp_addr_r <= exp_addr_nxt;
    data_r     <= data_nxt;
    crc_r      <= crc_nxt;
  end

  urdc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign in_stall     = buf_full;
  assign out_status   = out_res.status;
  assign out_reg_data = out_res.data;

  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_active_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (ticks_r != 16'h0))
    else $error("frame active with no ticks left");

  a_collect_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COLLECT) |-> (cnt_r <= LAST_DATA))
    else $error("byte count past check byte");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_reg_data == 32'h0))
    else $error("nonzero data on error status");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (phase_r == PH_IDLE))
    else $error("result issued without ending the frame");

endmodule
